// File: rtl/tzif_pkg.sv
// Package for the TZif UTC offset resolver: word types, parse phases, status codes.
// No dependencies.
`timescale 1ns / 1ps
package tzif_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } tzif_in_t;

  typedef struct packed {
    logic signed [31:0] offset_seconds;
    logic [1:0]         status;
  } tzif_out_t;

  typedef enum logic [3:0] {
    PH_MAGIC1 = 4'd0, PH_VER1 = 4'd1, PH_RES1 = 4'd2, PH_CNT1 = 4'd3,
    PH_SKIP = 4'd4, PH_MAGIC2 = 4'd5, PH_VER2 = 4'd6, PH_RES2 = 4'd7,
    PH_CNT2 = 4'd8, PH_TIMES = 4'd9, PH_TIX = 4'd10, PH_TTINFO = 4'd11,
    PH_DONE = 4'd12
  } tzif_phase_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
  localparam logic [1:0] ST_TRUNC     = 2'd2;
  localparam logic [1:0] ST_NO_TYPE   = 2'd3;

  localparam logic [7:0] VERSION_2 = 8'h32;
  localparam int unsigned RES_LEN = 15;
  localparam int unsigned NUM_COUNTS = 6;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    case (idx)
      2'd0:    magic_byte = 8'h54;
      2'd1:    magic_byte = 8'h5A;
      2'd2:    magic_byte = 8'h69;
      default: magic_byte = 8'h66;
    endcase
  endfunction

  // result produced by the parser on one word
  typedef struct packed {
    logic      fire;
    tzif_out_t res;
  } tzif_res_t;

endpackage

// File: rtl/tzif_parser.sv
// TZif byte parser: phase sequencing, counts, transition scan and type selection.
// Depends on tzif_pkg.
`timescale 1ns / 1ps
module tzif_parser import tzif_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  tzif_in_t           word,
  input  logic signed [63:0] query_time,
  output tzif_res_t          result
);

  tzif_phase_t  phase_r, phase_nxt;
  logic [3:0]   cnt_r, cnt_nxt;
  logic [63:0]  shift_r, shift_nxt;
  logic [7:0]   ver_r, ver_nxt;
  logic [31:0]  cnts_r [NUM_COUNTS];
  logic [31:0]  cnt_val;
  logic         cnt_we;
  logic [2:0]   cidx_r, cidx_nxt;
  logic [31:0]  idx_r, idx_nxt;
  logic [39:0]  skip_r, skip_nxt;
  logic         best_v_r, best_v_nxt;
  logic [31:0]  best_r, best_nxt;
  logic         ch_v_r, ch_v_nxt;
  logic [7:0]   ch_r, ch_nxt;
  logic [31:0]  sel_r, sel_nxt, fb_r, fb_nxt;
  logic         f_off_r, f_off_nxt, f_std_r, f_std_nxt, f_giv_r, f_giv_nxt;

  logic [7:0]   b;
  logic [63:0]  sh8;
  logic         v2;
  logic [3:0]   twidth;
  logic signed [63:0] tval;
  logic [32:0]  idx_p1;
  logic [39:0]  skip_sum;
  logic         fire;
  logic [1:0]   rstat;
  logic [31:0]  roff;

  assign b      = word.data_byte;
  assign sh8    = {shift_r[55:0], b};
  assign v2     = ver_r >= VERSION_2;
  assign twidth = v2 ? 4'd8 : 4'd4;
  assign tval   = v2 ? sh8 : {{32{sh8[31]}}, sh8[31:0]};
  assign idx_p1 = {1'b0, idx_r} + 33'd1;
  // the last count (charcnt) is still on its way into cnts_r
  assign skip_sum = {8'd0, cnts_r[3]} * 40'd5 + {8'd0, cnts_r[4]} * 40'd6
                  + {8'd0, cnt_val} + {8'd0, cnts_r[2]} * 40'd8
                  + {8'd0, cnts_r[1]} + {8'd0, cnts_r[0]};

  always_comb begin
    logic [31:0] c3, c4;
    logic        do_tix, do_tt, do_fin;
    phase_nxt = phase_r; cnt_nxt = cnt_r; shift_nxt = shift_r; ver_nxt = ver_r;
    cidx_nxt = cidx_r; idx_nxt = idx_r; skip_nxt = skip_r;
    best_v_nxt = best_v_r; best_nxt = best_r; ch_v_nxt = ch_v_r; ch_nxt = ch_r;
    sel_nxt = sel_r; fb_nxt = fb_r; f_off_nxt = f_off_r; f_std_nxt = f_std_r;
    f_giv_nxt = f_giv_r;
    cnt_val = sh8[31:0]; cnt_we = 1'b0;
    fire = 1'b0; rstat = ST_OK; roff = '0;
    do_tix = 1'b0; do_tt = 1'b0; do_fin = 1'b0;
    c3 = cnts_r[3]; c4 = cnts_r[4];
    case (phase_r)
      PH_MAGIC1, PH_MAGIC2: begin
        if (b != magic_byte(cnt_r[1:0])) begin
          fire = 1'b1; rstat = ST_BAD_MAGIC;
        end else if (cnt_r == 4'd3) begin
          cnt_nxt = '0;
          phase_nxt = (phase_r == PH_MAGIC1) ? PH_VER1 : PH_VER2;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      PH_VER1, PH_VER2: begin
        if (phase_r == PH_VER1) ver_nxt = b;
        cnt_nxt = '0;
        phase_nxt = (phase_r == PH_VER1) ? PH_RES1 : PH_RES2;
      end
      PH_RES1, PH_RES2: begin
        if (cnt_r == 4'(RES_LEN - 1)) begin
          cnt_nxt = '0; cidx_nxt = '0; shift_nxt = '0;
          phase_nxt = (phase_r == PH_RES1) ? PH_CNT1 : PH_CNT2;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      PH_CNT1, PH_CNT2: begin
        shift_nxt = sh8;
        if (cnt_r == 4'd3) begin
          cnt_we = 1'b1; cnt_nxt = '0; shift_nxt = '0;
          if (cidx_r == 3'(NUM_COUNTS - 1)) begin
            if (cidx_r == 3'd3) c3 = cnt_val;
            if (phase_r == PH_CNT1 && v2) begin
              skip_nxt = skip_sum;
              phase_nxt = (skip_sum == '0) ? PH_MAGIC2 : PH_SKIP;
            end else begin
              phase_nxt = PH_TIMES; idx_nxt = '0; best_v_nxt = 1'b0;
              if (c3 == '0) do_tix = 1'b1;
            end
          end else begin
            cidx_nxt = cidx_r + 3'd1;
          end
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      PH_SKIP: begin
        skip_nxt = skip_r - 40'd1;
        if (skip_r == 40'd1) phase_nxt = PH_MAGIC2;
      end
      PH_TIMES: begin
        shift_nxt = sh8;
        if (cnt_r + 4'd1 == twidth) begin
          if (tval <= query_time) begin
            best_v_nxt = 1'b1; best_nxt = idx_r;
          end
          cnt_nxt = '0; shift_nxt = '0;
          if (idx_p1 >= {1'b0, c3}) do_tix = 1'b1;
          else idx_nxt = idx_p1[31:0];
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      PH_TIX: begin
        if (best_v_r && idx_r == best_r) begin
          ch_v_nxt = 1'b1; ch_nxt = b;
        end
        if (idx_p1 >= {1'b0, c3}) do_tt = 1'b1;
        else idx_nxt = idx_p1[31:0];
      end
      PH_TTINFO: begin
        if (cnt_r < 4'd4) shift_nxt = sh8;
        else if (cnt_r == 4'd4) begin
          if (ch_v_r && idx_r == {24'd0, ch_r}) begin
            sel_nxt = shift_r[31:0]; f_off_nxt = 1'b1;
          end
          if (!f_std_r && b == 8'd0) begin
            fb_nxt = shift_r[31:0]; f_std_nxt = 1'b1;
          end
        end
        if (cnt_r == 4'd5) begin
          cnt_nxt = '0; shift_nxt = '0;
          if (idx_p1 >= {1'b0, c4}) do_fin = 1'b1;
          else idx_nxt = idx_p1[31:0];
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      default: ;
    endcase
    if (do_tix) begin
      phase_nxt = PH_TIX; idx_nxt = '0; ch_v_nxt = 1'b0;
      if (c3 == '0) do_tt = 1'b1;
    end
    if (do_tt) begin
      phase_nxt = PH_TTINFO; idx_nxt = '0; cnt_nxt = '0; shift_nxt = '0;
      f_off_nxt = 1'b0; f_std_nxt = 1'b0;
      if (c4 == '0) do_fin = 1'b1;
    end
    if (do_fin) begin
      fire = 1'b1;
      if (f_off_nxt) begin
        rstat = ST_OK; roff = sel_nxt;
      end else if (f_std_nxt) begin
        rstat = ST_OK; roff = fb_nxt;
      end else begin
        rstat = ST_NO_TYPE;
      end
    end
    if (fire) begin
      f_giv_nxt = 1'b1; phase_nxt = PH_DONE;
    end
    if (word.last_byte && !fire && !f_giv_r) begin
      fire = 1'b1; rstat = ST_TRUNC; roff = '0;
    end
    if (rstat != ST_OK) roff = '0;
  end

  assign result.fire = step && fire;
  assign result.res.offset_seconds = roff;
  assign result.res.status = rstat;

  always_ff @(posedge clk) begin
    if (!rst_n || (step && word.last_byte)) begin
      phase_r <= PH_MAGIC1; cnt_r <= '0; shift_r <= '0; ver_r <= '0;
      cidx_r <= '0; idx_r <= '0; skip_r <= '0; best_v_r <= 1'b0;
      ch_v_r <= 1'b0; f_off_r <= 1'b0; f_std_r <= 1'b0; f_giv_r <= 1'b0;
      sel_r <= '0; fb_r <= '0; best_r <= '0; ch_r <= '0;
      for (int i = 0; i < NUM_COUNTS; i++) cnts_r[i] <= '0;
    end else if (step) begin
      phase_r <= phase_nxt; cnt_r <= cnt_nxt; shift_r <= shift_nxt;
      ver_r <= ver_nxt; cidx_r <= cidx_nxt; idx_r <= idx_nxt; skip_r <= skip_nxt;
      best_v_r <= best_v_nxt; best_r <= best_nxt; ch_v_r <= ch_v_nxt; ch_r <= ch_nxt;
      sel_r <= sel_nxt; fb_r <= fb_nxt; f_off_r <= f_off_nxt; f_std_r <= f_std_nxt;
      f_giv_r <= f_giv_nxt;
      if (cnt_we) cnts_r[cidx_r] <= cnt_val;
    end
  end

  ap_done_given: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DONE) |-> f_giv_r) else $error("done without result");
  ap_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < 4'd15) else $error("byte count overflow");
  ap_skip_nz: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SKIP) |-> (skip_r != '0)) else $error("skip count zero");

endmodule

// File: rtl/tzif_utc_offset_resolver.sv
// Top level of the TZif UTC offset resolver: input register, parser, output register.
// Depends on tzif_pkg and tzif_parser.
`timescale 1ns / 1ps
// Takes one TZif file byte per cycle and gives at most one result word per file:
// the UTC offset in force at cfg query time, or an error status. Each accepted byte
// is registered, parsed combinationally, and its result (if any) lands in the
// output register; the block sustains one byte per cycle and stalls input only
// when both the input and output registers are held. Write cfg_query_time only
// while the block is idle.
module tzif_utc_offset_resolver import tzif_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [63:0] cfg_query_time,
  input  logic        in_valid,
  output logic        in_stall,
  input  tzif_in_t    in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output tzif_out_t   out_word
);

  logic [63:0] qt_r;
  logic        iv_r;
  tzif_in_t    iw_r;
  tzif_res_t   res;
  logic        step, out_free;

  assign out_free = !out_valid || !out_stall;
  assign step     = iv_r && out_free;
  assign in_stall = iv_r && !out_free;

  tzif_parser u_parser (
    .clk, .rst_n, .step, .word(iw_r), .query_time(qt_r), .result(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qt_r <= '0; iv_r <= 1'b0; out_valid <= 1'b0;
    end else begin
      if (cfg_we) qt_r <= cfg_query_time;
      if (!in_stall) iv_r <= in_valid;
      if (out_free) out_valid <= res.fire;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) iw_r <= in_word;
    if (out_free && res.fire) out_word <= res.res;
  end

  ap_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  ap_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (iv_r && out_valid)) else $error("spurious stall");
  ap_ok_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.status != ST_OK) |-> (out_word.offset_seconds == 0))
    else $error("error with nonzero offset");

endmodule

// File: tb/testbench.sv
// Testbench for tzif_utc_offset_resolver: streams generated TZif files byte by byte
// and checks each result word against an in-bench parser model. Depends on tzif_pkg.
`timescale 1ns / 1ps
module testbench import tzif_pkg::*; ();

  localparam int HOLD_CYCLES = 250;
  localparam int STALL_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [63:0] cfg_query_time = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  tzif_in_t    in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  tzif_out_t   out_word;

  tzif_utc_offset_resolver u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_query_time(cfg_query_time),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  localparam logic [7:0] TZIF_MAGIC [4] = '{8'h54, 8'h5A, 8'h69, 8'h66};

  // parser model state
  tzif_phase_t        ph;
  int unsigned        fcnt;
  logic [63:0]        shift;
  logic [7:0]         ver;
  logic [31:0]        cnts [6];
  logic [31:0]        eidx;
  logic [63:0]        skip;
  longint             best;
  longint             chosen;
  logic [31:0]        sel_off, fb_off;
  bit                 have_sel, have_fb, given, got;
  logic signed [63:0] qtime = '0;

  tzif_out_t expected_words [$];
  int        errors = 0;
  int        bytes_sent = 0;
  bit        quiet = 1'b0;
  bit        hold_req = 1'b0;

  // file under construction
  logic [7:0]  fbytes [$];
  int unsigned cur_c [6];
  int          hdr2_pos;

  task clear_state();
    ph = PH_MAGIC1; fcnt = 0; shift = '0; ver = '0;
    for (int i = 0; i < 6; i++) cnts[i] = '0;
    eidx = '0; skip = '0; best = -1; chosen = -1;
    sel_off = '0; fb_off = '0; have_sel = 0; have_fb = 0; given = 0;
  endtask

  task give(input logic [1:0] st, input logic [31:0] off);
    tzif_out_t w;
    w.status = st;
    w.offset_seconds = (st == ST_OK) ? off : '0;
    expected_words.push_back(w);
    got = 1; given = 1; ph = PH_DONE;
  endtask

  task resolve_offset();
    if (have_sel) give(ST_OK, sel_off);
    else if (have_fb) give(ST_OK, fb_off);
    else give(ST_NO_TYPE, '0);
  endtask

  task enter_ttinfo();
    ph = PH_TTINFO; eidx = '0; fcnt = 0; shift = '0; have_sel = 0; have_fb = 0;
    if (cnts[4] == 0) resolve_offset();
  endtask

  task enter_tix();
    ph = PH_TIX; eidx = '0; chosen = -1;
    if (cnts[3] == 0) enter_ttinfo();
  endtask

  task enter_times();
    ph = PH_TIMES; eidx = '0; fcnt = 0; shift = '0; best = -1;
    if (cnts[3] == 0) enter_tix();
  endtask

  task parse_byte(input logic [7:0] b);
    longint t;
    int unsigned w;
    logic [63:0] nxt;
    nxt = {32'b0, eidx} + 64'd1;
    case (ph)
      PH_MAGIC1, PH_MAGIC2: begin
        if (b != TZIF_MAGIC[fcnt[1:0]]) begin
          give(ST_BAD_MAGIC, '0);
        end else begin
          fcnt++;
          if (fcnt == 4) begin
            fcnt = 0;
            ph = (ph == PH_MAGIC1) ? PH_VER1 : PH_VER2;
          end
        end
      end
      PH_VER1, PH_VER2: begin
        if (ph == PH_VER1) ver = b;
        fcnt = 0;
        ph = (ph == PH_VER1) ? PH_RES1 : PH_RES2;
      end
      PH_RES1, PH_RES2: begin
        fcnt++;
        if (fcnt == RES_LEN) begin
          fcnt = 0; eidx = '0; shift = '0;
          ph = (ph == PH_RES1) ? PH_CNT1 : PH_CNT2;
        end
      end
      PH_CNT1, PH_CNT2: begin
        shift = {shift[55:0], b};
        fcnt++;
        if (fcnt == 4) begin
          cnts[eidx % 6] = shift[31:0];
          fcnt = 0; shift = '0;
          eidx++;
          if (eidx >= NUM_COUNTS) begin
            if (ph == PH_CNT1 && ver >= VERSION_2) begin
              skip = {32'b0, cnts[3]} * 5 + {32'b0, cnts[4]} * 6 + {32'b0, cnts[5]} +
                     {32'b0, cnts[2]} * 8 + {32'b0, cnts[1]} + {32'b0, cnts[0]};
              fcnt = 0;
              ph = (skip == 0) ? PH_MAGIC2 : PH_SKIP;
            end else begin
              enter_times();
            end
          end
        end
      end
      PH_SKIP: begin
        skip--;
        if (skip == 0) ph = PH_MAGIC2;
      end
      PH_TIMES: begin
        w = (ver >= VERSION_2) ? 8 : 4;
        shift = {shift[55:0], b};
        fcnt++;
        if (fcnt == w) begin
          if (w == 4) t = longint'({{32{shift[31]}}, shift[31:0]});
          else t = longint'(shift);
          if (t <= qtime) best = longint'({32'b0, eidx});
          fcnt = 0; shift = '0;
          if (nxt >= {32'b0, cnts[3]}) enter_tix();
          else eidx++;
        end
      end
      PH_TIX: begin
        if (longint'({32'b0, eidx}) == best) chosen = longint'({56'b0, b});
        if (nxt >= {32'b0, cnts[3]}) enter_ttinfo();
        else eidx++;
      end
      PH_TTINFO: begin
        if (fcnt < 4) begin
          shift = {shift[55:0], b};
        end else if (fcnt == 4) begin
          if (longint'({32'b0, eidx}) == chosen) begin
            sel_off = shift[31:0]; have_sel = 1;
          end
          if (!have_fb && b == 8'h00) begin
            fb_off = shift[31:0]; have_fb = 1;
          end
        end
        fcnt++;
        if (fcnt == 6) begin
          fcnt = 0; shift = '0;
          if (nxt >= {32'b0, cnts[4]}) resolve_offset();
          else eidx++;
        end
      end
      default: ;
    endcase
  endtask

  task predict_byte(input logic [7:0] b, input logic last);
    got = 0;
    if (ph != PH_DONE) parse_byte(b);
    if (last && !got && !given) give(ST_TRUNC, '0);
    if (last) clear_state();
  endtask

  // one word onto the input channel, optionally after a random gap
  task send_byte(input logic [7:0] b, input logic last);
    tzif_in_t w;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    w.data_byte = b;
    w.last_byte = last;
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    predict_byte(b, last);
    bytes_sent++;
  endtask

  task wait_idle();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task set_query(input logic [63:0] v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_query_time <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    qtime = v;
  endtask

  task send_file();
    for (int i = 0; i < fbytes.size(); i++) send_byte(fbytes[i], i == fbytes.size() - 1);
  endtask

  task put32(input logic [31:0] v);
    for (int i = 3; i >= 0; i--) fbytes.push_back(v[i*8 +: 8]);
  endtask

  task set_counts(input int unsigned a, b, c, d, e, f);
    cur_c[0] = a; cur_c[1] = b; cur_c[2] = c; cur_c[3] = d; cur_c[4] = e; cur_c[5] = f;
  endtask

  task rand_counts();
    set_counts($urandom_range(0, 2), $urandom_range(0, 2), $urandom_range(0, 1),
               $urandom_range(0, 4), $urandom_range(0, 3), $urandom_range(0, 4));
  endtask

  task put_hdr(input logic [7:0] v);
    for (int i = 0; i < 4; i++) fbytes.push_back(TZIF_MAGIC[i]);
    fbytes.push_back(v);
    for (int i = 0; i < RES_LEN; i++) fbytes.push_back(8'($urandom));
    for (int i = 0; i < 6; i++) put32(cur_c[i]);
  endtask

  function automatic logic [63:0] pick_time(input bit w64);
    logic [63:0] t;
    case ($urandom_range(0, 7))
      0: t = qtime - 1;
      1: t = qtime;
      2: t = qtime + 1;
      3: t = 64'h8000_0000_0000_0000;
      4: t = 64'h7FFF_FFFF_FFFF_FFFF;
      5: t = {{32{1'b1}}, 32'h8000_0000};
      default: t = {$urandom, $urandom};
    endcase
    if (!w64) t = {{32{t[31]}}, t[31:0]};
    return t;
  endfunction

  task put_block(input bit w64);
    logic [63:0] t;
    logic [31:0] off;
    int extra;
    for (int i = 0; i < cur_c[3]; i++) begin
      t = pick_time(w64);
      if (w64) put32(t[63:32]);
      put32(t[31:0]);
    end
    for (int i = 0; i < cur_c[3]; i++)
      fbytes.push_back($urandom_range(0, 7) == 0 ? 8'($urandom) : 8'($urandom_range(0, cur_c[4])));
    for (int i = 0; i < cur_c[4]; i++) begin
      case ($urandom_range(0, 5))
        0: off = 32'h8000_0000;
        1: off = 32'h7FFF_FFFF;
        default: off = $urandom;
      endcase
      put32(off);
      fbytes.push_back($urandom_range(0, 7) == 0 ? 8'($urandom) : 8'($urandom_range(0, 1)));
      fbytes.push_back(8'($urandom));
    end
    extra = cur_c[5] + cur_c[2] * (w64 ? 12 : 8) + cur_c[1] + cur_c[0];
    for (int i = 0; i < extra; i++) fbytes.push_back(8'($urandom));
  endtask

  task build_random_file();
    int mode;
    int pos;
    fbytes.delete();
    hdr2_pos = 0;
    if ($urandom_range(0, 1) == 0) begin
      rand_counts();
      put_hdr($urandom_range(0, 2) == 0 ? 8'($urandom_range(0, 8'h31)) : 8'h00);
      put_block(0);
    end else begin
      rand_counts();
      put_hdr($urandom_range(0, 3) == 0 ? 8'($urandom_range(8'h32, 8'hFF)) : 8'h32);
      put_block(0);
      hdr2_pos = fbytes.size();
      rand_counts();
      put_hdr(8'($urandom));
      put_block(1);
      fbytes.push_back(8'h0A);
      repeat ($urandom_range(0, 4)) fbytes.push_back(8'($urandom));
      fbytes.push_back(8'h0A);
    end
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      pos = $urandom_range(1, fbytes.size() - 1);
      while (fbytes.size() > pos) void'(fbytes.pop_back());
    end else if (mode == 1) begin
      pos = ((hdr2_pos != 0 && $urandom_range(0, 1)) ? hdr2_pos : 0) + $urandom_range(0, 3);
      fbytes[pos] = fbytes[pos] ^ 8'($urandom_range(1, 255));
    end else if (mode == 2) begin
      fbytes.delete();
      repeat ($urandom_range(1, 6)) fbytes.push_back(8'($urandom));
    end
  endtask

  // result word checker
  always @(posedge clk) begin
    tzif_out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $error("unexpected result word: offset %0d status %0d",
               out_word.offset_seconds, out_word.status);
        errors++;
      end else begin
        e = expected_words.pop_front();
        if (out_word.offset_seconds !== e.offset_seconds) begin
          $error("offset_seconds: expected %0d, actual %0d",
                 e.offset_seconds, out_word.offset_seconds);
          errors++;
        end
        if (out_word.status !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, out_word.status);
          errors++;
        end
      end
    end
  end

  // receiver stall
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL tzif_utc_offset_resolver");
        $finish;
      end
    end
  end

  task test_directed();
    // zero counts, version 1: no type at all
    fbytes.delete(); set_counts(0, 0, 0, 0, 0, 0); put_hdr(8'h00); send_file();
    // one standard type, no transitions: fallback offset
    fbytes.delete(); set_counts(0, 0, 0, 0, 1, 0); put_hdr(8'h31);
    put32(32'h7FFF_FFFF); fbytes.push_back(8'h00); fbytes.push_back(8'h00); send_file();
    // all types dst, index out of range
    fbytes.delete(); set_counts(0, 0, 0, 1, 1, 0); put_hdr(8'h00);
    put32(32'h8000_0000); fbytes.push_back(8'h05);
    put32(32'h1234_5678); fbytes.push_back(8'h01); fbytes.push_back(8'h00);
    fbytes.push_back(8'hAA); fbytes.push_back(8'h55); send_file();
    // version 0xFF with empty first block, trailing bytes after result
    fbytes.delete(); set_counts(0, 0, 0, 0, 0, 0); put_hdr(8'hFF);
    set_counts(0, 0, 0, 1, 1, 0); put_hdr(8'h00);
    put32(32'h0); put32(32'h0); fbytes.push_back(8'h00);
    put32(32'hFFFF_FFFF); fbytes.push_back(8'h01); fbytes.push_back(8'hFF);
    fbytes.push_back(8'hFF); fbytes.push_back(8'h00); send_file();
    // bad magic on each position of the first header
    for (int p = 0; p < 4; p++) begin
      fbytes.delete(); set_counts(0, 0, 0, 0, 0, 0); put_hdr(8'h32);
      fbytes[p] = ~fbytes[p];
      send_file();
    end
    // bad magic in the second header
    fbytes.delete(); set_counts(0, 0, 0, 0, 0, 0); put_hdr(8'h32);
    fbytes.push_back(8'h54); fbytes.push_back(8'h00); send_file();
    // huge counts, file ends early
    fbytes.delete(); set_counts(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    put_hdr(8'h32); fbytes.push_back(8'h00); send_file();
    fbytes.delete(); set_counts(0, 0, 0, 32'hFFFF_FFFF, 1, 0); put_hdr(8'h00);
    put32(32'h0); send_file();
    // single-byte file
    send_byte(8'h00, 1'b1);
  endtask

  task test_random(input int bytes_goal);
    while (bytes_sent < bytes_goal) begin
      build_random_file();
      send_file();
    end
  endtask

  task test_backpressure();
    wait_idle();
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++) send_byte(8'($urandom_range(0, 8'h53)), 1'b1);
    wait_idle();
  endtask

  task test_pause();
    build_random_file();
    send_file();
    wait_idle();
    build_random_file();
    send_file();
  endtask

  initial begin
    clear_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    set_query(64'h8000_0000_0000_0000);
    test_random(650);
    set_query(64'h7FFF_FFFF_FFFF_FFFF);
    test_random(720);
    set_query(64'h0000_0000_5F00_0000);
    test_random(790);
    test_backpressure();
    set_query({$urandom, $urandom});
    test_pause();
    set_query(64'hFFFF_FFFF_FFFF_FFFF);
    test_random(1050);
    set_query(64'h0);
    wait_idle();
    quiet = 1'b1;
    test_random(1150);
    wait_idle();
    if (errors == 0) begin
      $display("PASS tzif_utc_offset_resolver");
    end else begin
      $display("FAIL tzif_utc_offset_resolver");
    end
    $finish;
  end

endmodule
